FILE: src/mtep_pkg.sv
// Shared types and constants of the MIDI track event parser.
// No dependencies; the parser, queue, output stage and top level import this package.
`timescale 1ns / 1ps

package mtep_pkg;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_EVENT,
        PH_DATA1,
        PH_DATA2,
        PH_COMMON1,
        PH_COMMON2,
        PH_SYSEX_LEN,
        PH_SKIP,
        PH_META_TYPE,
        PH_META_LEN,
        PH_META_DATA
    } phase_t;

    typedef enum logic [2:0] {
        KIND_MSG,
        KIND_DELTA,
        KIND_TEMPO,
        KIND_SEEK,
        KIND_FINISH
    } kind_t;

    localparam int REG_MASTER_VOLUME = 0;
    localparam int REG_DEVICE_MASK   = 1;
    localparam int REG_SONG_LOOPING  = 2;

    localparam logic [15:0] MASTER_VOLUME_RESET = 16'hFFFF;
    localparam logic [15:0] DEVICE_MASK_RESET   = 16'hFF0F;

    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_CONT = 8'hF7;
    localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
    localparam logic [7:0] META_TEMPO      = 8'h51;

    localparam logic [2:0] CLASS_CONTROL = 3'd3;
    localparam logic [2:0] CLASS_PROGRAM = 3'd4;
    localparam logic [7:0] STATUS_PROGRAM = 8'hC0;

    localparam logic [7:0] CC_VOLUME       = 8'd7;
    localparam logic [7:0] CC_VOLUME_LSB   = 8'd39;
    localparam logic [7:0] CC_TRACK_DESIG  = 8'd110;
    localparam logic [7:0] CC_TRACK_EXCL   = 8'd111;
    localparam logic [7:0] CC_PROGRAM_SUB  = 8'd112;
    localparam logic [7:0] CC_VOLUME_SUB   = 8'd113;
    localparam logic [7:0] CC_LOOP_BEGIN   = 8'd116;
    localparam logic [7:0] CC_LOOP_END     = 8'd117;
    localparam logic [7:0] CC_GLOOP_BEGIN  = 8'd118;
    localparam logic [7:0] CC_GLOOP_END    = 8'd119;
    localparam logic [7:0] DATA_ALL        = 8'd127;
    localparam logic [15:0] DESIG_ALL      = 16'hFFFF;
    localparam logic [7:0] LOOP_NONE       = 8'hFF;

    // Data bytes per channel message class 0x8 through 0xE.
    localparam logic [1:0] MSG_LENGTHS [7] = '{2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QLEVEL_BITS = 3;

    typedef struct packed {
        logic [15:0] master_volume;
        logic [15:0] device_mask;
        logic        song_looping;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  status_byte;
        logic [6:0]  first_data;
        logic [7:0]  second_data;
        logic [31:0] delta_ticks;
        logic [23:0] tempo_value;
        logic [23:0] seek_position;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        logic [QLEVEL_BITS-1:0] level;
        logic                   room;
        logic                   nonempty;
    } q_status_t;

endpackage

FILE: src/mtep_if.sv
// Handshake channels of the parser: track bytes in, results out.
// No dependencies.
`timescale 1ns / 1ps

interface mtep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       track_start;

    modport source (output valid, data_byte, last_byte, track_start, input ready);
    modport sink   (input valid, data_byte, last_byte, track_start, output ready);
endinterface

interface mtep_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [7:0]  second_data;
    logic [31:0] delta_ticks;
    logic [23:0] tempo_value;
    logic [23:0] seek_position;
    logic        last_result;

    modport source (output valid, kind, status_byte, first_data, second_data,
                    delta_ticks, tempo_value, seek_position, last_result,
                    input ready);
    modport sink   (input valid, kind, status_byte, first_data, second_data,
                    delta_ticks, tempo_value, seek_position, last_result,
                    output ready);
endinterface

FILE: src/mtep_front.sv
// Byte parser: decodes one track byte per beat into up to two results.
// Depends on mtep_pkg and mtep_if.
`timescale 1ns / 1ps

module mtep_front #(
    parameter int POSITION_BITS = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mtep_pkg::cfg_t  cfg,
    mtep_byte_if.sink       bytes_in,
    input  logic            room,
    output mtep_pkg::push_t push
);
    import mtep_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [7:0]               run_st_reg, run_st_next;
    logic [7:0]               cur_st_reg, cur_st_next;
    logic [7:0]               held_reg, held_next;
    logic [31:0]              len_reg, len_next;
    logic [31:0]              skip_reg, skip_next;
    logic [7:0]               meta_reg, meta_next;
    logic [23:0]              tempo_reg, tempo_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] lstart_reg, lstart_next;
    logic [7:0]               lrem_reg, lrem_next;
    logic                     desig_reg, desig_next;
    logic [15:0]              dbits_reg, dbits_next;
    logic                     prog_reg, prog_next;
    logic                     vol_reg, vol_next;
    logic                     done_reg, done_next;

    logic        accept;
    logic [7:0]  b;
    logic [31:0] acc_v;
    logic        msg_go, meta_done, drop, rewound;
    logic [7:0]  msg_st, msg_d1, msg_d2;
    logic [2:0]  cls;
    logic [24:0] vol_prod;
    logic [7:0]  scaled;
    logic [31:0] seek_wide;
    logic        prim_ok, fin_ok;
    result_t     prim, fin;

    assign bytes_in.ready = room;
    assign accept = bytes_in.valid && room;
    assign b = bytes_in.data_byte;

    function automatic logic [1:0] common_len(input logic [7:0] st);
        logic [1:0] n;
        case (st[3:0])
            4'h1, 4'h3: n = 2'd1;
            4'h2:       n = 2'd2;
            default:    n = 2'd0;
        endcase
        return n;
    endfunction

    always_comb
    begin
        phase_next  = phase_reg;
        run_st_next = run_st_reg;
        cur_st_next = cur_st_reg;
        held_next   = held_reg;
        len_next    = len_reg;
        skip_next   = skip_reg;
        meta_next   = meta_reg;
        tempo_next  = tempo_reg;
        pos_next    = pos_reg;
        lstart_next = lstart_reg;
        lrem_next   = lrem_reg;
        desig_next  = desig_reg;
        dbits_next  = dbits_reg;
        prog_next   = prog_reg;
        vol_next    = vol_reg;
        done_next   = done_reg;
        acc_v     = '0;
        msg_go    = 1'b0;
        meta_done = 1'b0;
        drop      = 1'b0;
        rewound   = 1'b0;
        msg_st    = '0;
        msg_d1    = '0;
        msg_d2    = '0;
        cls       = '0;
        vol_prod  = '0;
        scaled    = '0;
        seek_wide = '0;
        prim_ok   = 1'b0;
        fin_ok    = 1'b0;
        prim      = '0;
        fin       = '0;
        fin.kind  = KIND_FINISH;
        fin.last_result = 1'b1;

        if (accept)
        begin
            if (bytes_in.track_start)
            begin
                phase_next  = PH_DELTA;
                run_st_next = '0;
                cur_st_next = '0;
                held_next   = '0;
                len_next    = '0;
                skip_next   = '0;
                meta_next   = '0;
                tempo_next  = '0;
                pos_next    = '0;
                lstart_next = '0;
                lrem_next   = LOOP_NONE;
                desig_next  = 1'b0;
                dbits_next  = '0;
                prog_next   = 1'b0;
                vol_next    = 1'b0;
                done_next   = 1'b0;
            end

            if (!done_next)
            begin
                pos_next = pos_next + POSITION_BITS'(1);
                acc_v = {len_next[24:0], b[6:0]};
                case (phase_next)
                    PH_DELTA:
                    begin
                        len_next = acc_v;
                        if (!b[7])
                        begin
                            prim_ok = 1'b1;
                            prim.kind = KIND_DELTA;
                            prim.delta_ticks = acc_v;
                            len_next = '0;
                            phase_next = PH_EVENT;
                        end
                    end
                    PH_EVENT:
                    begin
                        if (b == STATUS_META)
                            phase_next = PH_META_TYPE;
                        else if (b == STATUS_SYSEX || b == STATUS_SYSEX_CONT)
                        begin
                            len_next = '0;
                            phase_next = PH_SYSEX_LEN;
                        end
                        else if (b[7:4] == 4'hF)
                        begin
                            cur_st_next = b;
                            if (common_len(b) == 2'd0)
                            begin
                                msg_go = 1'b1;
                                msg_st = b;
                            end
                            else
                                phase_next = PH_COMMON1;
                        end
                        else if (b[7])
                        begin
                            run_st_next = b;
                            cur_st_next = b;
                            phase_next = PH_DATA1;
                        end
                        else
                        begin
                            cur_st_next = run_st_next;
                            held_next = b;
                            if (cur_st_next[6:4] != 3'd7 && MSG_LENGTHS[cur_st_next[6:4]] == 2'd2)
                                phase_next = PH_DATA2;
                            else
                            begin
                                msg_go = 1'b1;
                                msg_st = cur_st_next;
                                msg_d1 = b;
                            end
                        end
                    end
                    PH_DATA1:
                    begin
                        held_next = b;
                        if (cur_st_next[6:4] != 3'd7 && MSG_LENGTHS[cur_st_next[6:4]] == 2'd2)
                            phase_next = PH_DATA2;
                        else
                        begin
                            msg_go = 1'b1;
                            msg_st = cur_st_next;
                            msg_d1 = b;
                        end
                    end
                    PH_DATA2, PH_COMMON2:
                    begin
                        msg_go = 1'b1;
                        msg_st = cur_st_next;
                        msg_d1 = held_next;
                        msg_d2 = b;
                    end
                    PH_COMMON1:
                    begin
                        held_next = b;
                        if (common_len(cur_st_next) == 2'd1)
                        begin
                            msg_go = 1'b1;
                            msg_st = cur_st_next;
                            msg_d1 = b;
                        end
                        else
                            phase_next = PH_COMMON2;
                    end
                    PH_SYSEX_LEN:
                    begin
                        len_next = acc_v;
                        if (!b[7])
                        begin
                            skip_next = acc_v;
                            len_next = '0;
                            phase_next = (acc_v != '0) ? PH_SKIP : PH_DELTA;
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_next - 32'd1;
                        if (skip_next == '0)
                            phase_next = PH_DELTA;
                    end
                    PH_META_TYPE:
                    begin
                        meta_next = b;
                        len_next = '0;
                        phase_next = PH_META_LEN;
                    end
                    PH_META_LEN:
                    begin
                        len_next = acc_v;
                        if (!b[7])
                        begin
                            skip_next = acc_v;
                            tempo_next = '0;
                            if (acc_v == '0)
                                meta_done = 1'b1;
                            else
                                phase_next = PH_META_DATA;
                        end
                    end
                    PH_META_DATA:
                    begin
                        if (len_next - skip_next < 32'd3)
                            tempo_next = {tempo_next[15:0], b};
                        skip_next = skip_next - 32'd1;
                        if (skip_next == '0)
                            meta_done = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_DELTA;
                        len_next = '0;
                    end
                endcase

                if (meta_done)
                begin
                    phase_next = PH_DELTA;
                    if (meta_next == META_END_OF_TRACK)
                    begin
                        prim_ok = 1'b1;
                        prim.kind = KIND_FINISH;
                        done_next = 1'b1;
                    end
                    else if (meta_next == META_TEMPO && len_next >= 32'd3)
                    begin
                        prim_ok = 1'b1;
                        prim.kind = KIND_TEMPO;
                        prim.tempo_value = tempo_next;
                    end
                    len_next = '0;
                end

                if (msg_go)
                begin
                    phase_next = PH_DELTA;
                    len_next = '0;
                    cls = msg_st[6:4];
                    vol_prod = (25'(msg_d2) + 25'd1) * 25'(cfg.master_volume);
                    scaled = vol_prod[23:16];
                    if (cls == CLASS_PROGRAM && prog_next)
                        drop = 1'b1;
                    if (cls == CLASS_CONTROL)
                    begin
                        case (msg_d1)
                            CC_VOLUME:
                            begin
                                if (vol_next)
                                    drop = 1'b1;
                                else
                                    msg_d2 = scaled;
                            end
                            CC_VOLUME_LSB, CC_GLOOP_BEGIN, CC_GLOOP_END:
                                drop = 1'b1;
                            CC_TRACK_DESIG:
                            begin
                                if (msg_d2 == DATA_ALL)
                                    dbits_next = DESIG_ALL;
                                else if (msg_d2 <= 8'd9)
                                    dbits_next = dbits_next | (16'd1 << msg_d2[3:0]);
                                desig_next = 1'b1;
                                drop = 1'b1;
                            end
                            CC_TRACK_EXCL:
                            begin
                                if (desig_next && msg_d2 < 8'd16)
                                    dbits_next = dbits_next & ~(16'd1 << msg_d2[3:0]);
                                drop = 1'b1;
                            end
                            CC_PROGRAM_SUB:
                            begin
                                prog_next = 1'b1;
                                msg_st = STATUS_PROGRAM | {4'h0, msg_st[3:0]};
                                msg_d1 = msg_d2;
                                msg_d2 = '0;
                            end
                            CC_VOLUME_SUB:
                            begin
                                vol_next = 1'b1;
                                msg_d1 = CC_VOLUME;
                                msg_d2 = scaled;
                            end
                            CC_LOOP_BEGIN:
                            begin
                                lstart_next = pos_next;
                                lrem_next = msg_d2;
                                drop = 1'b1;
                            end
                            CC_LOOP_END:
                            begin
                                if (!lrem_next[7] && msg_d2 == DATA_ALL)
                                begin
                                    if (lrem_next == '0 && !cfg.song_looping)
                                    begin
                                        prim_ok = 1'b1;
                                        prim.kind = KIND_FINISH;
                                        done_next = 1'b1;
                                    end
                                    else
                                    begin
                                        if (lrem_next != '0)
                                        begin
                                            lrem_next = lrem_next - 8'd1;
                                            if (lrem_next == '0)
                                                lrem_next = LOOP_NONE;
                                        end
                                        pos_next = lstart_next;
                                        rewound = 1'b1;
                                        seek_wide = 32'(lstart_next);
                                        prim_ok = 1'b1;
                                        prim.kind = KIND_SEEK;
                                        prim.seek_position = seek_wide[23:0];
                                    end
                                end
                                drop = 1'b1;
                            end
                            default:
                                drop = drop;
                        endcase
                    end
                    if (!drop && (!desig_next || (dbits_next & cfg.device_mask) != '0))
                    begin
                        prim_ok = 1'b1;
                        prim.kind = KIND_MSG;
                        prim.status_byte = msg_st;
                        prim.first_data = msg_d1[6:0];
                        prim.second_data = msg_d2;
                    end
                end

                if (bytes_in.last_byte && !rewound && !done_next)
                begin
                    fin_ok = 1'b1;
                    done_next = 1'b1;
                end
            end
        end

        // The finish result always comes last when a byte yields two.
        push = '0;
        if (prim_ok)
        begin
            push.r0 = prim;
            push.r0.last_result = !fin_ok;
            push.r1 = fin;
            push.count = fin_ok ? 2'd2 : 2'd1;
        end
        else
        begin
            push.r0 = fin;
            push.r1 = fin;
            push.count = fin_ok ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DELTA;
            run_st_reg <= '0;
            cur_st_reg <= '0;
            held_reg   <= '0;
            len_reg    <= '0;
            skip_reg   <= '0;
            meta_reg   <= '0;
            tempo_reg  <= '0;
            pos_reg    <= '0;
            lstart_reg <= '0;
            lrem_reg   <= LOOP_NONE;
            desig_reg  <= 1'b0;
            dbits_reg  <= '0;
            prog_reg   <= 1'b0;
            vol_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            run_st_reg <= run_st_next;
            cur_st_reg <= cur_st_next;
            held_reg   <= held_next;
            len_reg    <= len_next;
            skip_reg   <= skip_next;
            meta_reg   <= meta_next;
            tempo_reg  <= tempo_next;
            pos_reg    <= pos_next;
            lstart_reg <= lstart_next;
            lrem_reg   <= lrem_next;
            desig_reg  <= desig_next;
            dbits_reg  <= dbits_next;
            prog_reg   <= prog_next;
            vol_reg    <= vol_next;
            done_reg   <= done_next;
        end
    end

endmodule

FILE: src/mtep_queue.sv
// Result queue between parser and output stage: two writes, one read per cycle.
// Depends on mtep_pkg.
`timescale 1ns / 1ps

module mtep_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mtep_pkg::push_t      push,
    input  logic                 pop,
    output mtep_pkg::result_t    head,
    output mtep_pkg::q_status_t  status
);
    import mtep_pkg::*;

    result_t                entries [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_reg, wr_next;
    logic [QPTR_BITS-1:0]   rd_reg, rd_next;
    logic [QLEVEL_BITS-1:0] level_reg, level_next;
    logic                   do_pop;

    assign do_pop = pop && (level_reg != '0);
    assign head = entries[rd_reg];
    assign status.level = level_reg;
    assign status.nonempty = (level_reg != '0);
    // Room for the worst case of two results from the next beat.
    assign status.room = (level_reg <= QLEVEL_BITS'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_next = wr_reg + QPTR_BITS'(push.count);
        rd_next = rd_reg + QPTR_BITS'(do_pop);
        level_next = level_reg + QLEVEL_BITS'(push.count) - QLEVEL_BITS'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entries[wr_reg] <= push.r0;
        if (push.count == 2'd2)
            entries[wr_reg + QPTR_BITS'(1)] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            level_reg <= level_next;
        end
    end

endmodule

FILE: src/mtep_back.sv
// Output register stage: drains the result queue onto the result channel.
// Depends on mtep_pkg and mtep_if.
`timescale 1ns / 1ps

module mtep_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mtep_pkg::result_t head,
    input  logic              nonempty,
    output logic              pop,
    mtep_result_if.source     results
);
    import mtep_pkg::*;

    logic    valid_reg, valid_next;
    result_t out_reg, out_next;

    assign pop = nonempty && (!valid_reg || results.ready);

    always_comb
    begin
        valid_next = valid_reg;
        out_next = out_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            out_next = head;
        end
        else if (results.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign results.valid         = valid_reg;
    assign results.kind          = out_reg.kind;
    assign results.status_byte   = out_reg.status_byte;
    assign results.first_data    = out_reg.first_data;
    assign results.second_data   = out_reg.second_data;
    assign results.delta_ticks   = out_reg.delta_ticks;
    assign results.tempo_value   = out_reg.tempo_value;
    assign results.seek_position = out_reg.seek_position;
    assign results.last_result   = out_reg.last_result;

endmodule

FILE: src/midi_track_event_parser.sv
// MIDI track event parser top level: config registers, parser, queue, output stage.
// Decode is combinational; results pass through the queue to the output register,
// the end of track result second. Throughput: one byte per cycle while the queue has
// room; results leave the output register at one per cycle while the consumer is
// ready. Reset clears all parser state; the registers take their defaults.
`timescale 1ns / 1ps

module midi_track_event_parser #(
    parameter int POSITION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    mtep_byte_if.sink     track_bytes,
    mtep_result_if.source results
);
    import mtep_pkg::*;

    // Configuration registers. Writes must come only while the block is idle; the block
    // does not enforce this. The parser reads them directly without any staging.
    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                2'(REG_MASTER_VOLUME): cfg_next.master_volume = cfg_data;
                2'(REG_DEVICE_MASK):   cfg_next.device_mask = cfg_data;
                2'(REG_SONG_LOOPING):  cfg_next.song_looping = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.master_volume <= MASTER_VOLUME_RESET;
            cfg_reg.device_mask <= DEVICE_MASK_RESET;
            cfg_reg.song_looping <= 1'b0;
        end
        else
            cfg_reg <= cfg_next;
    end

    // The front parser takes a beat whenever the queue can hold the two
    // results a single byte may cause; it never looks at the output side.
    push_t     push;
    result_t   head;
    q_status_t qstat;
    logic      pop;

    mtep_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .bytes_in (track_bytes),
        .room     (qstat.room),
        .push     (push)
    );

    mtep_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (qstat)
    );

    // The back stage holds one result; the queue drains into it only while it is empty
    // or the consumer takes the held result.
    mtep_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .nonempty (qstat.nonempty),
        .pop      (pop),
        .results  (results)
    );

    // The queue never overfills.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.level <= QLEVEL_BITS'(QUEUE_DEPTH))
        else $error("result queue level beyond depth");

    // No beat is taken without room for two results.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> qstat.room)
        else $error("results pushed without queue room");

    // A held result is only dropped after the consumer took it.
    a_out_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(results.valid) |-> $past(results.ready))
        else $error("result lost from output stage");

endmodule
